/* rtl/core/drpd_pkg.sv */
// ----------------------------------------------------------------------------
// drpd_pkg
// Shared types and constants of the delta / run-length pixel decoder.
// ----------------------------------------------------------------------------
package drpd_pkg;

  // Stream control codes and the pixel sign flip.
  localparam logic [7:0]  CODE_TOGGLE = 8'h80;
  localparam logic [7:0]  CODE_RUN    = 8'h81;
  localparam logic [15:0] SIGN_FLIP   = 16'h8000;

  // Parser phases.
  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [15:0] DIM_RESET   = 16'd256;
  localparam logic [31:0] TOTAL_RESET = 32'd65536;

  // One decoded result.
  typedef struct packed {
    logic [15:0] pixel;
    logic [7:0]  count;
    logic        last;
  } drpd_res_t;

endpackage

/* rtl/core/drpd_cfg.sv */
// ----------------------------------------------------------------------------
// drpd_cfg
// Image size registers and the registered pixel total of one image.
// ----------------------------------------------------------------------------
module drpd_cfg
  import drpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic [31:0] total_o
);

  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;

  // Size registers, written directly from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The product follows the size registers in the next cycle, which is
  // before any byte accepted after a write reaches the decoder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else begin
      total_r <= {16'd0, width_r} * {16'd0, height_r};
    end
  end

  assign total_o = total_r;

endmodule

/* rtl/core/drpd_core.sv */
// ----------------------------------------------------------------------------
// drpd_core
// Byte parser, pixel reconstruction and run clipping with the image state.
// ----------------------------------------------------------------------------
module drpd_core
  import drpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] total_i,
  output logic        res_valid_o,
  output drpd_res_t   res_o
);

  logic [1:0]  phase_r;
  logic [1:0]  phase_nxt;
  logic        mode_r;
  logic        mode_nxt;
  logic [15:0] pixel_r;
  logic [15:0] pixel_nxt;
  logic [31:0] done_r;
  logic [31:0] done_nxt;

  logic        emit;
  logic [7:0]  run_len;
  logic [32:0] remain_ext;
  logic        remain_zero;
  logic        clip;
  logic [7:0]  count;
  logic        last;

  // Decode one byte against the current phase and mode.
  always_comb begin
    phase_nxt = PH_CODE;
    mode_nxt  = mode_r;
    pixel_nxt = pixel_r;
    emit      = 1'b0;
    run_len   = 8'd1;
    unique case (phase_r)
      PH_LOW: begin
        pixel_nxt = {pixel_r[15:8], byte_i};
        emit      = 1'b1;
      end
      PH_COUNT: begin
        run_len = byte_i;
        emit    = (byte_i != 8'd0);
      end
      default: begin
        if (byte_i == CODE_TOGGLE) begin
          mode_nxt = ~mode_r;
        end else if (byte_i == CODE_RUN) begin
          phase_nxt = PH_COUNT;
        end else if (mode_r) begin
          pixel_nxt = pixel_r + {{8{byte_i[7]}}, byte_i};
          emit      = 1'b1;
        end else begin
          pixel_nxt = {byte_i, 8'h00};
          phase_nxt = PH_LOW;
        end
      end
    endcase
  end

  // Pixels left in the image; a borrow means none are left.
  assign remain_ext  = {1'b0, total_i} - {1'b0, done_r};
  assign remain_zero = remain_ext[32] || (remain_ext[31:0] == 32'd0);
  assign clip        = !remain_zero && ({24'd0, run_len} > remain_ext[31:0]);
  assign count       = clip ? remain_ext[7:0] : run_len;
  assign last        = remain_zero || ({24'd0, run_len} >= remain_ext[31:0]);
  assign done_nxt    = done_r + {24'd0, count};

  assign res_valid_o  = emit;
  assign res_o.pixel  = pixel_nxt ^ SIGN_FLIP;
  assign res_o.count  = count;
  assign res_o.last   = last;

  // Image state; the last result of an image restarts everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      mode_r  <= 1'b0;
      pixel_r <= 16'd0;
      done_r  <= 32'd0;
    end else if (go_i) begin
      if (emit && last) begin
        phase_r <= PH_CODE;
        mode_r  <= 1'b0;
        pixel_r <= 16'd0;
        done_r  <= 32'd0;
      end else begin
        phase_r <= phase_nxt;
        mode_r  <= mode_nxt;
        pixel_r <= pixel_nxt;
        if (emit) begin
          done_r <= done_nxt;
        end
      end
    end
  end

endmodule

/* rtl/core/delta_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// delta_rle_pixel_decoder
// Decodes a delta / run-length compressed 16-bit image byte stream.
// ----------------------------------------------------------------------------
// The compressed stream enters one byte per transfer on the in_ channel.
// Each decoded pixel or run leaves as one transfer on the out_ channel:
// tdata carries the offset-binary pixel and its repeat count, tlast marks
// the result that completes the image. Bytes that produce no pixel (mode
// toggles, run codes, high bytes, zero counts) produce no transfer.
// The image size is set on the cfg_ port (index 0 width, index 1 height)
// and applies once the registered pixel total has followed the write.
// Each byte is captured in an input register, decoded combinationally and
// its result lands in an output register, from which it leaves on the
// out_ channel. One byte is accepted per cycle through the single decode
// stage and its state update while the output register is free or being
// taken by the receiver.
// When the receiver stalls with a result pending, the decode stage holds
// one byte and in_tready drops until the output register is freed.
// Reset clears the valid flags of both registers and the image state and
// loads a 256 by 256 image size.
// ----------------------------------------------------------------------------
module delta_rle_pixel_decoder
  import drpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] stream_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [15:0] pixel_out, [23:16] repeat_count
  output logic        out_tlast,   // image_last
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  drpd_res_t   out_res_r;
  logic        advance;
  logic [31:0] total;
  logic        res_valid;
  drpd_res_t   res;

  drpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .total_o   (total)
  );

  drpd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go_i        (advance),
    .byte_i      (in_byte_r),
    .total_i     (total),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The held byte is decoded when the output register can take a result.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.pixel};
  assign out_tlast  = out_res_r.last;

endmodule

/* tb/delta_rle_pixel_decoder_test.sv */
// ----------------------------------------------------------------------------
// delta_rle_pixel_decoder_test
// Self-checking testbench of the delta / run-length pixel decoder.
// ----------------------------------------------------------------------------
// Compressed bytes go into the in_ stream. Each accepted byte runs through a
// behavioral decoder kept here, which queues the pixel runs it expects. Every
// out_ transfer is compared with the oldest queued run. Directed tests cover
// reference pixels, difference mode, zero and clipped runs, a shrunk image
// and the size extremes. One long output hold-off follows, then random
// images under bursty input and several output stall patterns.
// ----------------------------------------------------------------------------
module delta_rle_pixel_decoder_test
  import drpd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_READY, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_style_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // [15:0] pixel_out, [23:16] repeat_count
  logic        out_tlast;    // image_last
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  // Decoder state as predicted by the testbench.
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [1:0]  dec_phase;
  logic        dec_diff;
  logic [15:0] dec_pixel;
  logic [31:0] dec_done;

  drpd_res_t   pending_runs[$];
  int          mismatch_count;
  int          bytes_sent;

  // Sender and receiver pacing.
  bit          tx_gappy;
  int          burst_left;
  rx_style_t   rx_style;
  int          rx_hold;
  int          rx_tick;

  delta_rle_pixel_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Return to the start of an image.
  function automatic void restart_image();
    dec_phase = PH_CODE;
    dec_diff  = 1'b0;
    dec_pixel = 16'h0000;
    dec_done  = 32'd0;
  endfunction

  // Queue one run of the current pixel, clipped to what the image still holds.
  function automatic void emit_pixels(input logic [31:0] n);
    logic [63:0] total;
    logic [63:0] done;
    logic [63:0] left;
    logic [63:0] cnt;
    logic        fin;
    drpd_res_t   r;
    total = {48'd0, img_w};
    total = total * {48'd0, img_h};
    done  = {32'd0, dec_done};
    left  = (total > done) ? total - done : 64'd0;
    cnt   = {32'd0, n};
    if (cnt == 64'd0) return;
    if (left != 64'd0 && cnt > left) cnt = left;
    fin = (left == 64'd0) || (done + cnt >= total);
    r.pixel = dec_pixel ^ SIGN_FLIP;
    r.count = cnt[7:0];
    r.last  = fin;
    pending_runs.push_back(r);
    if (fin) restart_image();
    else dec_done = dec_done + cnt[31:0];
  endfunction

  // Advance the predicted decoder by one stream byte.
  function automatic void decode_byte(input logic [7:0] b);
    case (dec_phase)
      PH_LOW: begin
        dec_pixel = {dec_pixel[15:8], b};
        dec_phase = PH_CODE;
        emit_pixels(32'd1);
      end
      PH_COUNT: begin
        dec_phase = PH_CODE;
        emit_pixels({24'd0, b});
      end
      default: begin
        dec_phase = PH_CODE;
        if (b == CODE_TOGGLE) begin
          dec_diff = ~dec_diff;
        end else if (b == CODE_RUN) begin
          dec_phase = PH_COUNT;
        end else if (dec_diff) begin
          dec_pixel = dec_pixel + {{8{b[7]}}, b};
          emit_pixels(32'd1);
        end else begin
          dec_pixel = {b, 8'h00};
          dec_phase = PH_LOW;
        end
      end
    endcase
  endfunction

  // A random byte that is neither control code.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CODE_TOGGLE || b == CODE_RUN);
    return b;
  endfunction

  // Offer one byte and wait for its transfer; starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
    if (tx_gappy) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending and wait until every queued run has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both size registers while the decoder is idle.
  task automatic set_image_size(input logic [15:0] w, input logic [15:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
    repeat (3) @(negedge clk);
  endtask

  // One well-formed piece of stream with random content, or some noise.
  task automatic send_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (dec_diff) begin
        send_byte(plain_byte());
      end else begin
        send_byte(plain_byte());
        send_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick < 55) begin
      send_byte(CODE_TOGGLE);
    end else if (pick < 87) begin
      send_byte(CODE_RUN);
      pick = $urandom_range(0, 9);
      if (pick < 2) send_byte(8'd0);
      else if (pick < 7) send_byte(8'($urandom_range(1, 8)));
      else send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Reference pixels at the ends of the range, default 256 by 256 image.
  task automatic test_reference_pixels();
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h7F); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'hFF);
  endtask

  // Signed differences that wrap around in both directions.
  task automatic test_difference_mode();
    send_byte(CODE_TOGGLE);
    send_byte(8'h7F);
    send_byte(8'h82);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CODE_TOGGLE);
  endtask

  // A zero count gives nothing; full and single runs.
  task automatic test_runs();
    send_byte(CODE_RUN); send_byte(8'h00);
    send_byte(CODE_RUN); send_byte(8'hFF);
    send_byte(CODE_RUN); send_byte(8'h01);
  endtask

  // Shrinking the image under the pixels already done ends it with an
  // unclipped run; the next image then clips an overlong run.
  task automatic test_resize_and_clip();
    set_image_size(16'd2, 16'd2);
    send_byte(CODE_RUN); send_byte(8'h05);
    send_byte(CODE_RUN); send_byte(8'h09);
  endtask

  // Smallest and largest image sizes.
  task automatic test_size_extremes();
    set_image_size(16'd1, 16'd1);
    send_byte(8'h12); send_byte(8'h34);
    set_image_size(16'hFFFF, 16'hFFFF);
    send_byte(CODE_RUN); send_byte(8'hFF);
  endtask

  // Hold the output off for a long stretch while bytes keep coming, so the
  // decoder fills and stalls its input; then pause until all runs are out.
  task automatic test_backpressure();
    set_image_size(16'd64, 16'd64);
    tx_gappy = 1'b0;
    rx_hold  = 150;
    if (!dec_diff) send_byte(CODE_TOGGLE);
    repeat (40) send_byte(plain_byte());
    drain();
  endtask

  // Random streams over a series of image sizes and pacing styles.
  task automatic test_random_streams();
    int target;
    for (int p = 0; p < 12; p++) begin
      case (p)
        3:       set_image_size(16'hFFFF, 16'd1);
        5:       set_image_size(16'd1, 16'd1);
        7:       set_image_size(16'd1, 16'hFFFF);
        10:      set_image_size(16'hFFFF, 16'hFFFF);
        default: set_image_size(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)));
      endcase
      rx_style = rx_style_t'(p % 4);
      tx_gappy = (p % 3) != 0;
      target   = bytes_sent + 100;
      while (bytes_sent < target) send_token();
    end
    drain();
  endtask

  // Receiver: stalls on its own pattern and counts down any hold-off.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        case (rx_style)
          RX_READY:   out_tready <= 1'b1;
          RX_RANDOM:  out_tready <= ($urandom_range(0, 9) >= 3);
          RX_PATTERN: out_tready <= ((rx_tick % 5) < 3);
          default:    out_tready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
      rx_tick++;
    end
  end

  // Compare each output transfer with the oldest queued run.
  always @(posedge clk) begin : check_results
    drpd_res_t want;
    drpd_res_t got;
    if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.pixel = out_tdata[15:0];
      got.count = out_tdata[23:16];
      got.last  = out_tlast;
      if (pending_runs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: pixel %h count %0d last %b",
                   got.pixel, got.count, got.last);
      end else begin
        want = pending_runs.pop_front();
        if (got.pixel !== want.pixel || got.count !== want.count ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected pixel %h count %0d last %b, got %h %0d %b",
                     want.pixel, want.count, want.last,
                     got.pixel, got.count, got.last);
        end
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_we    = 1'b0;
    cfg_index = CFG_IDX_WIDTH;
    cfg_wdata = 16'h0000;
    img_w     = DIM_RESET;
    img_h     = DIM_RESET;
    restart_image();
    mismatch_count = 0;
    bytes_sent = 0;
    tx_gappy   = 1'b0;
    burst_left = 0;
    rx_style   = RX_READY;
    rx_hold    = 0;
    rx_tick    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reference_pixels();
    test_difference_mode();
    test_runs();
    test_resize_and_clip();
    test_size_extremes();
    test_backpressure();
    test_random_streams();

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/drpd_pkg.sv
rtl/core/drpd_cfg.sv
rtl/core/drpd_core.sv
rtl/core/delta_rle_pixel_decoder.sv
tb/delta_rle_pixel_decoder_test.sv
